>>> rtl/d2s_pkg.sv
// Shared widths, register codes, record types and reciprocal tables for the DepthToSpace indexer.
`timescale 1ns / 1ps
package d2s_pkg;

  localparam int DEF_MAX_CHANNELS = 4096;
  localparam int DEF_MAX_HEIGHT   = 1024;
  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_BATCH    = 256;
  localparam int DEF_MAX_BLOCK    = 8;

  localparam int BS_W        = 4;
  localparam int SQ_W        = 8;
  localparam int CIN_W       = 13;
  localparam int HIN_W       = 11;
  localparam int WIN_W       = 11;
  localparam int HOUT_W      = 15;
  localparam int WOUT_W      = 15;
  localparam int N_W         = 8;
  localparam int C_W         = 12;
  localparam int ROW_W       = 13;
  localparam int COL_W       = 13;
  localparam int Q_W         = 13;
  localparam int OFS_W       = 4;
  localparam int KK_W        = 8;
  localparam int IDX_W       = 40;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 80;

  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_SIZE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE_SELECT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_IN_CHANNELS = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_IN_HEIGHT   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_IN_WIDTH    = 3'd4;

  localparam logic MODE_DCR = 1'b0;
  localparam logic MODE_CRD = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [BS_W-1:0]    bs;
    logic [SQ_W-1:0]    sq;
    logic [CIN_W-1:0]   cin;
    logic [HIN_W-1:0]   hin;
    logic [WIN_W-1:0]   win;
    logic [HOUT_W-1:0]  hout;
    logic [WOUT_W-1:0]  wout;
    logic [RECIP_W-1:0] rbs;
    logic [RECIP_W-1:0] rsq;
  } cfg_t;

  typedef struct packed {
    logic [N_W-1:0]   n;
    logic [C_W-1:0]   c;
    logic [ROW_W-1:0] h;
    logic [COL_W-1:0] w;
  } coord_t;

  typedef struct packed {
    logic             valid;
    coord_t           coord;
    logic [Q_W-1:0]   hi;
    logic [OFS_W-1:0] ho;
    logic [Q_W-1:0]   wi;
    logic [OFS_W-1:0] wo;
    logic [CIN_W-1:0] cout;
  } split_t;

  typedef struct packed {
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] dst;
    logic             oor;
  } result_t;

  // floor(2^16 / bs)
  function automatic logic [RECIP_W-1:0] recip_bs(input logic [BS_W-1:0] bs);
    logic [RECIP_W-1:0] r;
    case (bs)
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21845;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13107;
      4'd6:    r = 17'd10922;
      4'd7:    r = 17'd9362;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7281;
      4'd10:   r = 17'd6553;
      4'd11:   r = 17'd5957;
      4'd12:   r = 17'd5461;
      4'd13:   r = 17'd5041;
      4'd14:   r = 17'd4681;
      4'd15:   r = 17'd4369;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  // floor(2^16 / (bs * bs))
  function automatic logic [RECIP_W-1:0] recip_sq(input logic [BS_W-1:0] bs);
    logic [RECIP_W-1:0] r;
    case (bs)
      4'd2:    r = 17'd16384;
      4'd3:    r = 17'd7281;
      4'd4:    r = 17'd4096;
      4'd5:    r = 17'd2621;
      4'd6:    r = 17'd1820;
      4'd7:    r = 17'd1337;
      4'd8:    r = 17'd1024;
      4'd9:    r = 17'd809;
      4'd10:   r = 17'd655;
      4'd11:   r = 17'd541;
      4'd12:   r = 17'd455;
      4'd13:   r = 17'd387;
      4'd14:   r = 17'd334;
      4'd15:   r = 17'd291;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/depth_to_space_address.sv
// DepthToSpace address generator top level: config registers, pipeline and stream ports.
// Throughput: one request per cycle; the only stall source is m_axis_tready, absorbed by
// a one-entry skid buffer whose registered ready gates every pipeline stage.
// Reset: synchronous, clears all valid bits and loads the configuration defaults
// (block 2, DCR, 4 channels, 1 x 1 spatial); no clearing pass is needed.
`timescale 1ns / 1ps
module depth_to_space_address import d2s_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_BATCH    = DEF_MAX_BATCH,
  parameter int MAX_BLOCK    = DEF_MAX_BLOCK
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // batch_index, out_channel, out_row, out_col
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // src_index, dst_index
  output logic                  m_axis_tuser   // out_of_range
);

  // Raw configuration registers, as written.
  logic [BS_W-1:0]  block_size;
  logic             mode_select;
  logic [CIN_W-1:0] in_channels;
  logic [HIN_W-1:0] in_height;
  logic [WIN_W-1:0] in_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size  <= BS_W'(2);
      mode_select <= MODE_DCR;
      in_channels <= CIN_W'(4);
      in_height   <= HIN_W'(1);
      in_width    <= WIN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BLOCK_SIZE:  block_size  <= cfg_wdata[BS_W-1:0];
        REG_MODE_SELECT: mode_select <= cfg_wdata[0];
        REG_IN_CHANNELS: in_channels <= cfg_wdata[CIN_W-1:0];
        REG_IN_HEIGHT:   in_height   <= cfg_wdata[HIN_W-1:0];
        REG_IN_WIDTH:    in_width    <= cfg_wdata[WIN_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Derived configuration, reloaded every cycle. Writes must only happen with the
  // pipeline empty; the block does not enforce this. No stage reads cfg before the
  // coordinate is captured, so a request right after a write already sees the new values.
  cfg_t             cfg, cfg_next;
  logic [BS_W-1:0]  bs_eff;

  always_comb begin
    if (block_size == '0) begin
      bs_eff = BS_W'(1);
    end else if (32'(block_size) > 32'(MAX_BLOCK)) begin
      bs_eff = BS_W'(MAX_BLOCK);
    end else begin
      bs_eff = block_size;
    end
    cfg_next.mode = mode_select;
    cfg_next.bs   = bs_eff;
    cfg_next.sq   = SQ_W'(bs_eff) * SQ_W'(bs_eff);
    cfg_next.cin  = (32'(in_channels) > 32'(MAX_CHANNELS)) ? CIN_W'(MAX_CHANNELS) : in_channels;
    cfg_next.hin  = (32'(in_height) > 32'(MAX_HEIGHT)) ? HIN_W'(MAX_HEIGHT) : in_height;
    cfg_next.win  = (32'(in_width) > 32'(MAX_WIDTH)) ? WIN_W'(MAX_WIDTH) : in_width;
    cfg_next.hout = HOUT_W'(cfg_next.hin) * HOUT_W'(bs_eff);
    cfg_next.wout = WOUT_W'(cfg_next.win) * WOUT_W'(bs_eff);
    cfg_next.rbs  = recip_bs(bs_eff);
    cfg_next.rsq  = recip_sq(bs_eff);
  end

  always_ff @(posedge clk) begin
    cfg <= cfg_next;
  end

  // Whole pipeline advances together whenever the skid buffer has room.
  logic    adv;
  coord_t  in_coord;
  split_t  split;
  logic    res_valid;
  result_t res, out_res;

  // unpack the request: batch, channel, row, column from the lowest bit up
  assign in_coord = {s_axis_tdata[7:0], s_axis_tdata[19:8], s_axis_tdata[32:20],
                     s_axis_tdata[45:33]};

  // hold off requests while reset is applied
  assign s_axis_tready = adv && !rst;

  d2s_split u_split (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s_axis_tvalid && s_axis_tready),
    .in_coord (in_coord),
    .cfg      (cfg),
    .out      (split)
  );

  d2s_index #(
    .MAX_BATCH (MAX_BATCH)
  ) u_index (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in        (split),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  d2s_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res),
    .ready     (adv),
    .out_valid (m_axis_tvalid),
    .out_data  (out_res),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {out_res.dst, out_res.src};
  assign m_axis_tuser = out_res.oor;

endmodule

>>> rtl/d2s_split.sv
// Front stages: capture the coordinate, split row and column by the block size, derive C_out.
`timescale 1ns / 1ps
module d2s_split import d2s_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_valid,
  input  coord_t in_coord,
  input  cfg_t   cfg,
  output split_t out
);

  localparam int PR_W = ROW_W + RECIP_W;
  localparam int PC_W = CIN_W + RECIP_W;
  localparam int MB_W = Q_W + BS_W;
  localparam int MS_W = Q_W + SQ_W;

  // stage 1: captured coordinate
  logic   v1;
  coord_t c1;

  // stage 2: quotient estimates (true value or one less)
  logic           v2;
  coord_t         c2;
  logic [Q_W-1:0] qh2, qw2, qc2;

  // stage 3: estimates times divisor
  logic           v3;
  coord_t         c3;
  logic [Q_W-1:0] qh3, qw3, qc3;
  logic [Q_W-1:0] ph3, pw3, pc3;

  logic [PR_W-1:0] mh, mw;
  logic [PC_W-1:0] mc;
  logic [MB_W-1:0] bh, bw;
  logic [MS_W-1:0] bc;

  assign mh = PR_W'(c1.h) * PR_W'(cfg.rbs);
  assign mw = PR_W'(c1.w) * PR_W'(cfg.rbs);
  assign mc = PC_W'(cfg.cin) * PC_W'(cfg.rsq);

  assign bh = MB_W'(qh2) * MB_W'(cfg.bs);
  assign bw = MB_W'(qw2) * MB_W'(cfg.bs);
  assign bc = MS_W'(qc2) * MS_W'(cfg.sq);

  // stage 4: one correction step gives exact quotient and remainder
  split_t nxt;
  logic [ROW_W-1:0] rh;
  logic [COL_W-1:0] rw;
  logic [CIN_W-1:0] rc;
  logic             fh, fw, fc;

  always_comb begin
    rh = c3.h - ph3;
    rw = c3.w - pw3;
    rc = cfg.cin - pc3;
    fh = rh >= ROW_W'(cfg.bs);
    fw = rw >= COL_W'(cfg.bs);
    fc = rc >= CIN_W'(cfg.sq);
    nxt.valid = v3;
    nxt.coord = c3;
    nxt.hi    = qh3 + Q_W'(fh);
    nxt.wi    = qw3 + Q_W'(fw);
    nxt.ho    = fh ? OFS_W'(rh - ROW_W'(cfg.bs)) : OFS_W'(rh);
    nxt.wo    = fw ? OFS_W'(rw - COL_W'(cfg.bs)) : OFS_W'(rw);
    nxt.cout  = qc3 + CIN_W'(fc);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1       <= in_coord;
      c2       <= c1;
      qh2      <= mh[RECIP_SHIFT +: Q_W];
      qw2      <= mw[RECIP_SHIFT +: Q_W];
      qc2      <= mc[RECIP_SHIFT +: Q_W];
      c3       <= c2;
      qh3      <= qh2;
      qw3      <= qw2;
      qc3      <= qc2;
      ph3      <= bh[Q_W-1:0];
      pw3      <= bw[Q_W-1:0];
      pc3      <= bc[Q_W-1:0];
      out.coord <= nxt.coord;
      out.hi    <= nxt.hi;
      out.ho    <= nxt.ho;
      out.wi    <= nxt.wi;
      out.wo    <= nxt.wo;
      out.cout  <= nxt.cout;
    end
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out.valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out.valid <= nxt.valid;
    end
  end

endmodule

>>> rtl/d2s_index.sv
// Back stages: range check, source channel and the two multiply-accumulate chains.
`timescale 1ns / 1ps
module d2s_index import d2s_pkg::*; #(
  parameter int MAX_BATCH = DEF_MAX_BATCH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  split_t  in,
  input  cfg_t    cfg,
  output logic    res_valid,
  output result_t res
);

  localparam int NCIN_W = N_W + CIN_W;
  localparam int NCC_W  = NCIN_W + 1;
  localparam int CI_W   = C_W + SQ_W + 1;
  localparam int SB_W   = NCC_W + HIN_W + 1;

  // stage 5
  logic              v5, oor5;
  coord_t            c5;
  logic [Q_W-1:0]    hi5, wi5;
  logic [CIN_W-1:0]  cout5;
  logic [KK_W-1:0]   kk5;
  logic [NCIN_W-1:0] ncin5;
  logic [NCC_W-1:0]  ncc5;

  // stage 6
  logic              v6, oor6;
  logic [COL_W-1:0]  w6;
  logic [Q_W-1:0]    hi6, wi6;
  logic [NCIN_W-1:0] ncin6;
  logic [CIN_W-1:0]  ci6;
  logic [IDX_W-1:0]  dst6;

  // stage 7
  logic              v7, oor7;
  logic [Q_W-1:0]    hi7, wi7;
  logic [NCC_W-1:0]  sa7;
  logic [IDX_W-1:0]  dst7;

  // stage 8
  logic              v8, oor8;
  logic [Q_W-1:0]    wi8;
  logic [SB_W-1:0]   sb8;
  logic [IDX_W-1:0]  dst8;

  logic              oor_n;
  logic [CI_W-1:0]   ci_crd, ci_dcr;
  logic [IDX_W-1:0]  src_n;

  assign oor_n = (32'(in.coord.n) >= 32'(MAX_BATCH)) ||
                 (CIN_W'(in.coord.c) >= in.cout) ||
                 (HOUT_W'(in.coord.h) >= cfg.hout) ||
                 (WOUT_W'(in.coord.w) >= cfg.wout);

  assign ci_crd = CI_W'(c5.c) * CI_W'(cfg.sq) + CI_W'(kk5);
  assign ci_dcr = CI_W'(kk5) * CI_W'(cout5) + CI_W'(c5.c);
  assign src_n  = IDX_W'(sb8) * IDX_W'(cfg.win) + IDX_W'(wi8);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      v8        <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v5        <= in.valid;
      v6        <= v5;
      v7        <= v6;
      v8        <= v7;
      res_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oor5  <= oor_n;
      c5    <= in.coord;
      hi5   <= in.hi;
      wi5   <= in.wi;
      cout5 <= in.cout;
      kk5   <= KK_W'(in.ho) * KK_W'(cfg.bs) + KK_W'(in.wo);
      ncin5 <= NCIN_W'(in.coord.n) * NCIN_W'(cfg.cin);
      ncc5  <= NCC_W'(in.coord.n) * NCC_W'(in.cout) + NCC_W'(in.coord.c);

      oor6  <= oor5;
      w6    <= c5.w;
      hi6   <= hi5;
      wi6   <= wi5;
      ncin6 <= ncin5;
      ci6   <= (cfg.mode == MODE_CRD) ? ci_crd[CIN_W-1:0] : ci_dcr[CIN_W-1:0];
      dst6  <= IDX_W'(ncc5) * IDX_W'(cfg.hout) + IDX_W'(c5.h);

      oor7  <= oor6;
      hi7   <= hi6;
      wi7   <= wi6;
      sa7   <= NCC_W'(ncin6) + NCC_W'(ci6);
      dst7  <= dst6 * IDX_W'(cfg.wout) + IDX_W'(w6);

      oor8  <= oor7;
      wi8   <= wi7;
      sb8   <= SB_W'(sa7) * SB_W'(cfg.hin) + SB_W'(hi7);
      dst8  <= dst7;

      res.oor <= oor8;
      res.src <= oor8 ? '0 : src_n;
      res.dst <= oor8 ? '0 : dst8;
    end
  end

endmodule

>>> rtl/d2s_skid.sv
// Output skid buffer: registered ready toward the pipeline, registered valid toward the sink.
`timescale 1ns / 1ps
module d2s_skid import d2s_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_data,
  output logic    ready,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_ready
);

  logic    skid_valid;
  result_t skid_data;
  logic    take, to_main;

  assign ready   = !skid_valid;
  assign take    = in_valid && ready;
  assign to_main = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (to_main) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (to_main) begin
        out_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end else if (out_ready && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule

>>> dv/depth_to_space_address_test.sv
// Self-checking stream testbench for the DepthToSpace address generator.
`timescale 1ns / 1ps
module depth_to_space_address_test;
  import d2s_pkg::*;

  // Edges that wait_drained lets pass after the queues empty, so the pipeline can settle.
  localparam int LATENCY      = 9;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 150;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 75;

  // Raw register contents as last written; the effective sizes come from tensor_dims.
  typedef struct packed {
    logic [3:0]  bs;
    logic        mode;
    logic [12:0] cin;
    logic [10:0] hin;
    logic [10:0] win;
  } layout_t;

  typedef struct {
    longint unsigned bs, cin, hin, win, cout, hout, wout;
  } dims_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // batch_index, out_channel, out_row, out_col
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // src_index, dst_index
  logic                  m_axis_tuser;        // out_of_range

  // Register image seen by the predictor, starting from the reset defaults.
  layout_t model_layout = '{bs: 4'd2, mode: MODE_DCR, cin: 13'd4, hin: 11'd1, win: 11'd1};

  coord_t  pending_coords[$];     // requests waiting for the driver
  result_t expected_indices[$];   // predictions for requests already accepted
  int      src_idle_max = 0;
  int      snk_idle_max = 0;
  int      mismatches = 0;
  int      results_seen = 0;
  int      cycle_count = 0;

  depth_to_space_address i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clamp the raw registers to what the block actually uses and derive the output shape.
  function automatic dims_t tensor_dims(layout_t lay);
    dims_t d;
    d.bs   = (lay.bs == 0) ? 1 : (lay.bs > DEF_MAX_BLOCK) ? DEF_MAX_BLOCK : lay.bs;
    d.cin  = (lay.cin > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : lay.cin;
    d.hin  = (lay.hin > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : lay.hin;
    d.win  = (lay.win > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : lay.win;
    d.cout = d.cin / (d.bs * d.bs);
    d.hout = d.hin * d.bs;
    d.wout = d.win * d.bs;
    return d;
  endfunction

  // Source and destination NCHW indices for one output coordinate.
  function automatic result_t predict_indices(coord_t k, layout_t lay);
    dims_t           d;
    longint unsigned n, c, h, w, ho, wo, ci, src, dst;
    result_t         r;
    d = tensor_dims(lay);
    n = k.n;
    c = k.c;
    h = k.h;
    w = k.w;
    r = '0;
    r.oor = (n >= DEF_MAX_BATCH) || (c >= d.cout) || (h >= d.hout) || (w >= d.wout);
    if (!r.oor) begin
      ho = h % d.bs;
      wo = w % d.bs;
      // DCR walks the block offset outermost, CRD keeps the depth outermost
      if (lay.mode == MODE_DCR)
        ci = (ho * d.bs + wo) * d.cout + c;
      else
        ci = c * d.bs * d.bs + ho * d.bs + wo;
      src = ((n * d.cin + ci) * d.hin + h / d.bs) * d.win + w / d.bs;
      dst = ((n * d.cout + c) * d.hout + h) * d.wout + w;
      r.src = src[IDX_W-1:0];
      r.dst = dst[IDX_W-1:0];
    end
    return r;
  endfunction

  // Mostly coordinates inside the output tensor; the rest span the full field widths.
  function automatic coord_t random_coord(dims_t d);
    coord_t k;
    k.n = 8'($urandom);
    k.c = 12'($urandom);
    k.h = 13'($urandom);
    k.w = 13'($urandom);
    if (d.cout > 0 && $urandom_range(0, 7) != 0) begin
      k.c = 12'($urandom_range(0, d.cout - 1));
      k.h = 13'($urandom_range(0, d.hout - 1));
      k.w = 13'($urandom_range(0, d.wout - 1));
    end
    return k;
  endfunction

  // Mostly legal shapes with at least one output channel; now and then raw register noise.
  function automatic layout_t random_layout();
    layout_t lay;
    int      bs_eff;
    lay.bs   = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8));
    lay.mode = $urandom_range(0, 1) ? MODE_CRD : MODE_DCR;
    bs_eff   = (lay.bs == 0) ? 1 : (lay.bs > DEF_MAX_BLOCK) ? DEF_MAX_BLOCK : lay.bs;
    lay.cin  = 13'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(bs_eff * bs_eff, 4096));
    lay.hin  = 11'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                               : $urandom_range(1, 1024));
    lay.win  = 11'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                               : $urandom_range(1, 1024));
    return lay;
  endfunction

  // Drive one register write at the next edge and mirror it in the register image.
  task automatic load_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_BLOCK_SIZE:  model_layout.bs   = data[3:0];
      REG_MODE_SELECT: model_layout.mode = data[0];
      REG_IN_CHANNELS: model_layout.cin  = data;
      REG_IN_HEIGHT:   model_layout.hin  = data[10:0];
      REG_IN_WIDTH:    model_layout.win  = data[10:0];
      default: ;  // unmapped index, the block drops it
    endcase
  endtask

  // Write all five registers with junk in any unused upper bits, plus one stray index.
  task automatic load_layout(input layout_t lay);
    load_reg(REG_BLOCK_SIZE, {9'($urandom), lay.bs});
    load_reg(REG_MODE_SELECT, {12'($urandom), lay.mode});
    load_reg(3'($urandom_range(5, 7)), 13'($urandom));
    load_reg(REG_IN_CHANNELS, lay.cin);
    load_reg(REG_IN_HEIGHT, {2'($urandom), lay.hin});
    load_reg(REG_IN_WIDTH, {2'($urandom), lay.win});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every request is sent and answered, then let the pipeline settle.
  // Sample between edges so the driver's updates from the last edge are visible.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_coords.size() != 0 || s_axis_tvalid || expected_indices.size() != 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Request driver: predict on acceptance, then advance to the next request after its gap.
  always @(posedge clk) begin : request_driver
    coord_t req_coord;
    int     src_gap;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_indices.push_back(predict_indices(req_coord, model_layout));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_coords.size() > 0) begin
          req_coord = pending_coords.pop_front();
          s_axis_tdata <= {2'b00, req_coord.w, req_coord.h, req_coord.c, req_coord.n};
          s_axis_tvalid <= 1'b1;
          src_gap = $urandom_range(0, src_idle_max);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check against the oldest prediction and pace m_axis_tready.
  // Twice in the run it holds ready low for a long stretch so the pipeline backs up
  // and s_axis_tready has to drop.
  always @(posedge clk) begin : result_monitor
    result_t want;
    int      sink_wait;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_indices.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: src %h dst %h oor %b",
                     m_axis_tdata[IDX_W-1:0], m_axis_tdata[2*IDX_W-1:IDX_W], m_axis_tuser);
          mismatches++;
        end else begin
          want = expected_indices.pop_front();
          if (m_axis_tdata[IDX_W-1:0] !== want.src ||
              m_axis_tdata[2*IDX_W-1:IDX_W] !== want.dst ||
              m_axis_tuser !== want.oor) begin
            if (mismatches < 10)
              $display("result %0d: src %h (exp %h) dst %h (exp %h) oor %b (exp %b)",
                       results_seen, m_axis_tdata[IDX_W-1:0], want.src,
                       m_axis_tdata[2*IDX_W-1:IDX_W], want.dst, m_axis_tuser, want.oor);
            mismatches++;
          end
        end
        results_seen++;
        sink_wait = (results_seen % 300 == 180) ? LONG_HOLD : $urandom_range(0, snk_idle_max);
      end else if (sink_wait > 0) begin
        sink_wait--;
      end
      m_axis_tready <= (sink_wait == 0);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    layout_t corners[7];
    dims_t   d;
    coord_t  k;
    int      i;
    int      j;

    // Corner shapes: reset defaults, zero and oversized block, saturated sizes,
    // empty tensors and a channel count below one block.
    corners[0] = model_layout;
    corners[1] = '{bs: 4'd0,  mode: MODE_CRD, cin: 13'd8191, hin: 11'd2047, win: 11'd2047};
    corners[2] = '{bs: 4'd15, mode: MODE_DCR, cin: 13'd4096, hin: 11'd1024, win: 11'd1024};
    corners[3] = '{bs: 4'd2,  mode: MODE_DCR, cin: 13'd0,    hin: 11'd4,    win: 11'd4};
    corners[4] = '{bs: 4'd2,  mode: MODE_CRD, cin: 13'd3,    hin: 11'd4,    win: 11'd4};
    corners[5] = '{bs: 4'd3,  mode: MODE_DCR, cin: 13'd18,   hin: 11'd0,    win: 11'd5};
    corners[6] = '{bs: 4'd4,  mode: MODE_CRD, cin: 13'd32,   hin: 11'd7,    win: 11'd0};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: the first shape runs on the reset defaults without any write.
    for (i = 0; i < 7; i++) begin
      if (i > 0) begin
        wait_drained();
        load_layout(corners[i]);
      end
      src_idle_max = $urandom_range(0, 1) ? 9 : 0;
      snk_idle_max = $urandom_range(0, 1) ? 9 : 0;
      d = tensor_dims(model_layout);
      pending_coords.push_back('0);
      if (i == 0)
        pending_coords.push_back('1);
      k.n = 8'd255;
      k.c = 12'(d.cout - 1);
      k.h = 13'(d.hout - 1);
      k.w = 13'(d.wout - 1);
      if (d.cout > 0)
        pending_coords.push_back(k);
      // one step past the edge of the tensor, rotating through channel, row and column
      k = '0;
      case (i % 3)
        0: k.c = 12'(d.cout);
        1: k.h = 13'(d.hout);
        default: k.w = 13'(d.wout);
      endcase
      pending_coords.push_back(k);
    end

    // Random part: full-size and minimal shapes first, then random shapes.
    for (i = 0; i < RAND_PHASES; i++) begin
      wait_drained();
      if (i == 0)
        load_layout('{bs: 4'd8, mode: MODE_DCR, cin: 13'd4096, hin: 11'd1024, win: 11'd1024});
      else if (i == 1)
        load_layout('{bs: 4'd1, mode: MODE_CRD, cin: 13'd1, hin: 11'd1, win: 11'd1});
      else
        load_layout(random_layout());
      src_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
      snk_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
      d = tensor_dims(model_layout);
      for (j = 0; j < PHASE_ITEMS; j++)
        pending_coords.push_back(random_coord(d));
    end

    wait_drained();
    if (mismatches == 0 && expected_indices.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
